/* rtl/bvm_pkg.sv */
// ----------------------------------------------------------------------------
// bvm_pkg
// Widths, constants and register indexes of the battery voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned MV_W       = 15;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned FAIL_W     = 4;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam longint unsigned SAMPLE_MAX = 4095;
   localparam longint unsigned FAIL_LIMIT = 10;
   localparam longint unsigned MV_FULL    = 26900;

   // millivolt scaling: mv = (level * MV_RECIP) >> MV_SHIFT, exact floor
   localparam int unsigned     MV_SHIFT   = 30;
   localparam longint unsigned MV_RECIP   =
      (MV_FULL * (64'd1 << MV_SHIFT) + SAMPLE_MAX - 1) / SAMPLE_MAX;
   localparam int unsigned     MV_RECIP_W = $clog2(MV_RECIP + 1);
   localparam int unsigned     MV_PROD_W  = SAMPLE_W + MV_RECIP_W;

   // divide by three: q = (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x < 2**16
   localparam int unsigned     SUM_W      = SAMPLE_W + 2;
   localparam int unsigned     DIV3_SHIFT = 17;
   localparam longint unsigned DIV3_RECIP = ((64'd1 << DIV3_SHIFT) + 2) / 3;
   localparam int unsigned     DIV3_W     = $clog2(DIV3_RECIP + 1);
   localparam int unsigned     DIV3_PROD_W = SUM_W + DIV3_W;

   localparam logic CMD_CONV = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_LOW       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_HIGH      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_WARN_MV   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_CLEAR_MV = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSENT_MV     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUTDOWN_MV   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TICKS  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSE_ENABLE  = 3'd7;

   localparam logic [SAMPLE_W-1:0] RST_REF_LOW       = 12'd900;
   localparam logic [SAMPLE_W-1:0] RST_REF_HIGH      = 12'd1610;
   localparam logic [MV_W-1:0]     RST_LOW_WARN_MV   = 15'd11200;
   localparam logic [MV_W-1:0]     RST_WARN_CLEAR_MV = 15'd11280;
   localparam logic [MV_W-1:0]     RST_ABSENT_MV     = 15'd500;
   localparam logic [MV_W-1:0]     RST_SHUTDOWN_MV   = 15'd11000;
   localparam logic [CNT_W-1:0]    RST_SETTLE_TICKS  = 16'd1000;
   localparam logic                RST_SENSE_ENABLE  = 1'b1;

endpackage

/* rtl/bvm_req_if.sv */
// ----------------------------------------------------------------------------
// bvm_req_if
// Request channel: conversion sets and timer ticks.
// ----------------------------------------------------------------------------
interface bvm_req_if import bvm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                command;
   logic [SAMPLE_W-1:0] ref_sample;
   logic [SAMPLE_W-1:0] batt_sample;
   logic                on_mains;

   modport source (output valid, output command, output ref_sample, output batt_sample,
                   output on_mains, input ready);
   modport sink   (input valid, input command, input ref_sample, input batt_sample,
                   input on_mains, output ready);
endinterface

/* rtl/bvm_rsp_if.sv */
// ----------------------------------------------------------------------------
// bvm_rsp_if
// Response channel: monitor status after each transaction.
// ----------------------------------------------------------------------------
interface bvm_rsp_if import bvm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                accepted;
   logic [SAMPLE_W-1:0] filtered_level;
   logic [MV_W-1:0]     battery_mv;
   logic                low_warning;
   logic                battery_absent;
   logic                shutdown_request;
   logic                recalibrate;
   logic                no_sensing;

   modport source (output valid, output accepted, output filtered_level, output battery_mv,
                   output low_warning, output battery_absent, output shutdown_request,
                   output recalibrate, output no_sensing, input ready);
   modport sink   (input valid, input accepted, input filtered_level, input battery_mv,
                   input low_warning, input battery_absent, input shutdown_request,
                   input recalibrate, input no_sensing, output ready);
endinterface

/* rtl/battery_voltage_monitor_core.sv */
// ----------------------------------------------------------------------------
// battery_voltage_monitor_core
// Reference window check, battery IIR average, millivolt scaling and
// low/absent/shutdown status with a tick-counted settle delay.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle unless a stalled response backs up to
// the input, and each yields exactly one response, in order. A request runs
// through four registers: the input register, the filter/settle/fail-count
// update (one divide-by-three multiplier), the millivolt scaling multiplier,
// and the status-flag update that loads the response register. A stalled
// response backs up the pipeline one stage at a time; empty stages keep
// accepting. Write the csr port only while the pipeline is empty.
module battery_voltage_monitor_core import bvm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bvm_req_if.sink               req_chan,
   bvm_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef struct packed {
      logic                command;
      logic [SAMPLE_W-1:0] ref_sample;
      logic [SAMPLE_W-1:0] batt_sample;
      logic                on_mains;
   } req_type;

   typedef struct packed {
      logic                accepted;
      logic [SAMPLE_W-1:0] filter;
      logic [MV_W-1:0]     mv;
      logic                recal;
      logic                check_en;
      logic                on_mains;
      logic                no_sense;
   } mid_type;

   typedef struct packed {
      logic                accepted;
      logic [SAMPLE_W-1:0] filtered_level;
      logic [MV_W-1:0]     battery_mv;
      logic                low_warning;
      logic                battery_absent;
      logic                shutdown_request;
      logic                recalibrate;
      logic                no_sensing;
   } rsp_type;

   // configuration
   logic [SAMPLE_W-1:0] ref_low_ff, ref_high_ff;
   logic [MV_W-1:0]     low_warn_mv_ff, warn_clear_mv_ff, absent_mv_ff, shutdown_mv_ff;
   logic [CNT_W-1:0]    settle_ticks_ff;
   logic                sense_enable_ff;

   // pipeline
   logic    req_vld_ff, mid2_vld_ff, mid3_vld_ff, rsp_vld_ff;
   req_type req_ff;
   mid_type mid2_ff, mid2_in, mid3_ff, mid3_in;
   rsp_type rsp_ff, rsp_in;
   logic    en_req, en_mid2, en_mid3, en_rsp;

   // state
   logic [SAMPLE_W-1:0] filter_ff, filter_in;
   logic [FAIL_W-1:0]   fail_ff, fail_in;
   logic [CNT_W-1:0]    settle_cnt_ff, settle_cnt_in;
   logic                started_ff, started_in;
   logic                settled_ff, settled_in;
   logic                no_sense_ff, no_sense_in;
   logic                low_ff, low_in;
   logic                absent_ff, absent_in;
   logic                shut_ff, shut_in;

   logic                   step_a, step_c;
   logic [SUM_W-1:0]       avg_sum;
   logic [DIV3_PROD_W-1:0] avg_prod;
   logic [SAMPLE_W-1:0]    avg_new;
   logic                   ref_ok;
   logic [FAIL_W:0]        fail_inc;
   logic [CNT_W-1:0]       cnt_inc;
   logic [MV_PROD_W-1:0]   mv_prod, mv_quo;

   // handshake
   assign en_rsp  = !rsp_vld_ff || rsp_chan.ready;
   assign en_mid3 = !mid3_vld_ff || en_rsp;
   assign en_mid2 = !mid2_vld_ff || en_mid3;
   assign en_req  = !req_vld_ff || en_mid2;
   assign req_chan.ready = en_req;

   assign step_a = req_vld_ff && en_mid2;
   assign step_c = mid3_vld_ff && en_rsp;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_low_ff       <= RST_REF_LOW;
         ref_high_ff      <= RST_REF_HIGH;
         low_warn_mv_ff   <= RST_LOW_WARN_MV;
         warn_clear_mv_ff <= RST_WARN_CLEAR_MV;
         absent_mv_ff     <= RST_ABSENT_MV;
         shutdown_mv_ff   <= RST_SHUTDOWN_MV;
         settle_ticks_ff  <= RST_SETTLE_TICKS;
         sense_enable_ff  <= RST_SENSE_ENABLE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REF_LOW:       ref_low_ff       <= csr_wdata[SAMPLE_W-1:0];
            CSR_REF_HIGH:      ref_high_ff      <= csr_wdata[SAMPLE_W-1:0];
            CSR_LOW_WARN_MV:   low_warn_mv_ff   <= csr_wdata[MV_W-1:0];
            CSR_WARN_CLEAR_MV: warn_clear_mv_ff <= csr_wdata[MV_W-1:0];
            CSR_ABSENT_MV:     absent_mv_ff     <= csr_wdata[MV_W-1:0];
            CSR_SHUTDOWN_MV:   shutdown_mv_ff   <= csr_wdata[MV_W-1:0];
            CSR_SETTLE_TICKS:  settle_ticks_ff  <= csr_wdata[CNT_W-1:0];
            CSR_SENSE_ENABLE:  sense_enable_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage A: window check, average, fail count, settle counter
   assign avg_sum  = {2'b00, req_ff.batt_sample} + {1'b0, filter_ff, 1'b0};
   assign avg_prod = {{DIV3_W{1'b0}}, avg_sum} * {{SUM_W{1'b0}}, DIV3_W'(DIV3_RECIP)};
   assign avg_new  = avg_prod[DIV3_SHIFT +: SAMPLE_W];
   assign ref_ok   = (req_ff.ref_sample >= ref_low_ff) && (req_ff.ref_sample <= ref_high_ff);
   assign fail_inc = {1'b0, fail_ff} + (FAIL_W+1)'(1);
   assign cnt_inc  = (settle_cnt_ff != '1) ? settle_cnt_ff + CNT_W'(1) : settle_cnt_ff;

   always_comb begin
      filter_in     = filter_ff;
      fail_in       = fail_ff;
      settle_cnt_in = settle_cnt_ff;
      started_in    = started_ff;
      settled_in    = settled_ff;
      no_sense_in   = no_sense_ff;
      mid2_in       = '0;
      if (step_a) begin
         if (req_ff.command == CMD_TICK) begin
            if (started_ff && !settled_ff) begin
               settle_cnt_in = cnt_inc;
               if (cnt_inc >= settle_ticks_ff) begin
                  settled_in = 1'b1;
               end
            end
         end else if (ref_ok) begin
            fail_in   = '0;
            filter_in = avg_new;
            if (sense_enable_ff) begin
               if (!settled_ff && !started_ff) begin
                  started_in    = 1'b1;
                  settle_cnt_in = '0;
               end
            end else begin
               no_sense_in = 1'b1;
            end
         end else if (fail_inc > (FAIL_W+1)'(FAIL_LIMIT)) begin
            fail_in = '0;
         end else begin
            fail_in = fail_inc[FAIL_W-1:0];
         end
      end
      mid2_in.accepted = (req_ff.command == CMD_CONV) && ref_ok;
      mid2_in.filter   = filter_in;
      mid2_in.recal    = (req_ff.command == CMD_CONV) && !ref_ok &&
                         (fail_inc > (FAIL_W+1)'(FAIL_LIMIT));
      mid2_in.check_en = mid2_in.accepted && sense_enable_ff && settled_ff;
      mid2_in.on_mains = req_ff.on_mains;
      mid2_in.no_sense = no_sense_in;
   end

   // stage B: scale to millivolts
   assign mv_prod = {{MV_RECIP_W{1'b0}}, mid2_ff.filter} *
                    {{SAMPLE_W{1'b0}}, MV_RECIP_W'(MV_RECIP)};
   assign mv_quo  = mv_prod >> MV_SHIFT;

   always_comb begin
      mid3_in    = mid2_ff;
      mid3_in.mv = (mv_quo > MV_PROD_W'(MV_FULL)) ? MV_W'(MV_FULL) : mv_quo[MV_W-1:0];
   end

   // stage C: warning, absent and shutdown flags
   always_comb begin
      low_in    = low_ff;
      absent_in = absent_ff;
      shut_in   = shut_ff;
      if (step_c && mid3_ff.check_en) begin
         if ((mid3_ff.mv <= low_warn_mv_ff) && !mid3_ff.on_mains) begin
            low_in = 1'b1;
         end else if (mid3_ff.mv >= warn_clear_mv_ff) begin
            low_in    = 1'b0;
            absent_in = 1'b0;
         end
         if (mid3_ff.mv <= absent_mv_ff) begin
            absent_in = 1'b1;
         end
         if ((mid3_ff.filter != '0) && (mid3_ff.mv <= shutdown_mv_ff) &&
             !mid3_ff.on_mains) begin
            shut_in = 1'b1;
         end
      end
      rsp_in.accepted         = mid3_ff.accepted;
      rsp_in.filtered_level   = mid3_ff.filter;
      rsp_in.battery_mv       = mid3_ff.mv;
      rsp_in.low_warning      = low_in;
      rsp_in.battery_absent   = absent_in;
      rsp_in.shutdown_request = shut_in;
      rsp_in.recalibrate      = mid3_ff.recal;
      rsp_in.no_sensing       = mid3_ff.no_sense;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff    <= 1'b0;
         mid2_vld_ff   <= 1'b0;
         mid3_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         filter_ff     <= '0;
         fail_ff       <= '0;
         settle_cnt_ff <= '0;
         started_ff    <= 1'b0;
         settled_ff    <= 1'b0;
         no_sense_ff   <= 1'b0;
         low_ff        <= 1'b0;
         absent_ff     <= 1'b0;
         shut_ff       <= 1'b0;
      end else begin
         if (en_req) begin
            req_vld_ff <= req_chan.valid;
         end
         if (en_mid2) begin
            mid2_vld_ff <= req_vld_ff;
         end
         if (en_mid3) begin
            mid3_vld_ff <= mid2_vld_ff;
         end
         if (en_rsp) begin
            rsp_vld_ff <= mid3_vld_ff;
         end
         filter_ff     <= filter_in;
         fail_ff       <= fail_in;
         settle_cnt_ff <= settle_cnt_in;
         started_ff    <= started_in;
         settled_ff    <= settled_in;
         no_sense_ff   <= no_sense_in;
         low_ff        <= low_in;
         absent_ff     <= absent_in;
         shut_ff       <= shut_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en_req) begin
         req_ff.command     <= req_chan.command;
         req_ff.ref_sample  <= req_chan.ref_sample;
         req_ff.batt_sample <= req_chan.batt_sample;
         req_ff.on_mains    <= req_chan.on_mains;
      end
      if (en_mid2) begin
         mid2_ff <= mid2_in;
      end
      if (en_mid3) begin
         mid3_ff <= mid3_in;
      end
      if (en_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.accepted         = rsp_ff.accepted;
   assign rsp_chan.filtered_level   = rsp_ff.filtered_level;
   assign rsp_chan.battery_mv       = rsp_ff.battery_mv;
   assign rsp_chan.low_warning      = rsp_ff.low_warning;
   assign rsp_chan.battery_absent   = rsp_ff.battery_absent;
   assign rsp_chan.shutdown_request = rsp_ff.shutdown_request;
   assign rsp_chan.recalibrate      = rsp_ff.recalibrate;
   assign rsp_chan.no_sensing       = rsp_ff.no_sensing;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_voltage_monitor_core.
// Conversion sets and timer ticks go in under random back-pressure on both
// channels. A cycle-free copy of the window check, the IIR average, the
// millivolt scaling, the settle counter and the status flags predicts each
// response, which is compared field by field in arrival order. Register
// settings change between phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb;
   import bvm_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 10;

   typedef struct packed {
      logic                command;
      logic [SAMPLE_W-1:0] ref_sample;
      logic [SAMPLE_W-1:0] batt_sample;
      logic                on_mains;
   } reading_type;

   typedef struct packed {
      logic                accepted;
      logic [SAMPLE_W-1:0] filtered_level;
      logic [MV_W-1:0]     battery_mv;
      logic                low_warning;
      logic                battery_absent;
      logic                shutdown_request;
      logic                recalibrate;
      logic                no_sensing;
   } status_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;
   reading_type           drive_q     = '0;
   logic                  drive_valid = 1'b0;
   logic                  rsp_ready_q = 1'b0;
   logic                  req_taken   = 1'b0;

   bvm_req_if req_if ();
   bvm_rsp_if rsp_if ();

   assign req_if.valid       = drive_valid;
   assign req_if.command     = drive_q.command;
   assign req_if.ref_sample  = drive_q.ref_sample;
   assign req_if.batt_sample = drive_q.batt_sample;
   assign req_if.on_mains    = drive_q.on_mains;
   assign rsp_if.ready       = rsp_ready_q;

   battery_voltage_monitor_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies
   logic [SAMPLE_W-1:0] win_lo        = RST_REF_LOW;
   logic [SAMPLE_W-1:0] win_hi        = RST_REF_HIGH;
   logic [MV_W-1:0]     warn_set_mv   = RST_LOW_WARN_MV;
   logic [MV_W-1:0]     warn_clr_mv   = RST_WARN_CLEAR_MV;
   logic [MV_W-1:0]     absent_set_mv = RST_ABSENT_MV;
   logic [MV_W-1:0]     shut_set_mv   = RST_SHUTDOWN_MV;
   logic [CNT_W-1:0]    settle_len    = RST_SETTLE_TICKS;
   logic                sensing_on    = RST_SENSE_ENABLE;

   // monitor state
   logic [SAMPLE_W-1:0] avg_level    = '0;
   logic [FAIL_W-1:0]   reject_run   = '0;
   logic [CNT_W-1:0]    settle_count = '0;
   logic                settle_armed = 1'b0;
   logic                settle_done  = 1'b0;
   logic                low_st       = 1'b0;
   logic                absent_st    = 1'b0;
   logic                shut_st      = 1'b0;
   logic                nosense_st   = 1'b0;

   reading_type pending_readings [$];
   status_type  status_due [$];
   int       queued_total  = 0;
   int       taken_total   = 0;
   int       errors        = 0;
   int       send_idle_pct = 28;
   int       recv_idle_pct = 63;
   int       tick_pct      = 30;
   int       burst_left    = 0;
   int       reject_left   = 0;
   logic [SAMPLE_W-1:0] aim = '0;

   function automatic logic [MV_W-1:0] scale_mv(logic [SAMPLE_W-1:0] level);
      longint unsigned mv;
      mv = 64'(level) * MV_FULL / SAMPLE_MAX;
      if (mv > MV_FULL) mv = MV_FULL;
      return mv[MV_W-1:0];
   endfunction

   function automatic status_type predict_status(reading_type r);
      status_type      s;
      logic [MV_W-1:0] mv;
      int unsigned     sum;
      s = '0;
      if (r.command == CMD_TICK) begin
         if (settle_armed && !settle_done) begin
            if (settle_count != {CNT_W{1'b1}}) settle_count = settle_count + 1'b1;
            if (settle_count >= settle_len) settle_done = 1'b1;
         end
      end else if (r.ref_sample >= win_lo && r.ref_sample <= win_hi) begin
         s.accepted = 1'b1;
         reject_run = '0;
         sum = 32'(r.batt_sample) + 2 * 32'(avg_level);
         avg_level = SAMPLE_W'(sum / 3);
         if (sensing_on) begin
            if (settle_done) begin
               mv = scale_mv(avg_level);
               if (mv <= warn_set_mv && !r.on_mains) begin
                  low_st = 1'b1;
               end else if (mv >= warn_clr_mv) begin
                  low_st    = 1'b0;
                  absent_st = 1'b0;
               end
               if (mv <= absent_set_mv) absent_st = 1'b1;
               if (avg_level != 0 && mv <= shut_set_mv && !r.on_mains) shut_st = 1'b1;
            end else if (!settle_armed) begin
               settle_armed = 1'b1;
               settle_count = '0;
            end
         end else begin
            nosense_st = 1'b1;
         end
      end else begin
         if (reject_run >= FAIL_LIMIT) begin
            reject_run    = '0;
            s.recalibrate = 1'b1;
         end else begin
            reject_run = reject_run + 1'b1;
         end
      end
      s.filtered_level   = avg_level;
      s.battery_mv       = scale_mv(avg_level);
      s.low_warning      = low_st;
      s.battery_absent   = absent_st;
      s.shutdown_request = shut_st;
      s.no_sensing       = nosense_st;
      return s;
   endfunction

   function automatic reading_type next_reading();
      reading_type         r;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      longint unsigned     thr;
      int                  lvl;
      lo = (win_lo <= win_hi) ? win_lo : win_hi;
      hi = (win_lo <= win_hi) ? win_hi : win_lo;
      r.command  = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_CONV;
      r.on_mains = ($urandom_range(99) < 30);
      // aim the battery level at a threshold for a burst of sets
      if (burst_left == 0) begin
         burst_left = $urandom_range(20, 4);
         case ($urandom_range(6))
            0:       thr = warn_set_mv;
            1:       thr = warn_clr_mv;
            2:       thr = absent_set_mv;
            3:       thr = shut_set_mv;
            4:       thr = 0;
            5:       thr = MV_FULL;
            default: thr = $urandom_range(MV_FULL);
         endcase
         lvl = int'((thr * SAMPLE_MAX + MV_FULL - 1) / MV_FULL);
         aim = (lvl > int'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(lvl);
      end
      burst_left--;
      if ($urandom_range(9) == 0) begin
         r.batt_sample = SAMPLE_W'($urandom);
      end else begin
         lvl = int'(aim) + int'($urandom_range(6)) - 3;
         if (lvl < 0) lvl = 0;
         if (lvl > int'(SAMPLE_MAX)) lvl = int'(SAMPLE_MAX);
         r.batt_sample = SAMPLE_W'(lvl);
      end
      // occasional run of rejected sets to reach the recalibrate pulse
      if (reject_left == 0 && $urandom_range(49) == 0) reject_left = $urandom_range(14, 8);
      if (reject_left > 0) begin
         reject_left--;
         if (lo > 0 && (hi == SAMPLE_MAX || $urandom_range(1) == 0))
            r.ref_sample = SAMPLE_W'($urandom_range(lo - 1, 0));
         else if (hi < SAMPLE_MAX)
            r.ref_sample = SAMPLE_W'($urandom_range(SAMPLE_MAX, hi + 1));
         else
            r.ref_sample = SAMPLE_W'($urandom);
      end else begin
         case ($urandom_range(9))
            0:       r.ref_sample = $urandom_range(1) ? win_lo : win_hi;
            1:       r.ref_sample = $urandom_range(1) ? win_lo - 1'b1 : win_hi + 1'b1;
            2, 3:    r.ref_sample = SAMPLE_W'($urandom);
            default: r.ref_sample = SAMPLE_W'($urandom_range(hi, lo));
         endcase
      end
      return r;
   endfunction

   function automatic void push_reading(reading_type r);
      pending_readings.push_back(r);
      queued_total++;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_REF_LOW:       win_lo        = val[SAMPLE_W-1:0];
         CSR_REF_HIGH:      win_hi        = val[SAMPLE_W-1:0];
         CSR_LOW_WARN_MV:   warn_set_mv   = val[MV_W-1:0];
         CSR_WARN_CLEAR_MV: warn_clr_mv   = val[MV_W-1:0];
         CSR_ABSENT_MV:     absent_set_mv = val[MV_W-1:0];
         CSR_SHUTDOWN_MV:   shut_set_mv   = val[MV_W-1:0];
         CSR_SETTLE_TICKS:  settle_len    = val[CNT_W-1:0];
         CSR_SENSE_ENABLE:  sensing_on    = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int lo, input int hi, input int warn, input int clr,
                             input int absent, input int shut, input int settle,
                             input int sense);
      write_reg(CSR_REF_LOW,       CSR_DATA_W'(lo));
      write_reg(CSR_REF_HIGH,      CSR_DATA_W'(hi));
      write_reg(CSR_LOW_WARN_MV,   CSR_DATA_W'(warn));
      write_reg(CSR_WARN_CLEAR_MV, CSR_DATA_W'(clr));
      write_reg(CSR_ABSENT_MV,     CSR_DATA_W'(absent));
      write_reg(CSR_SHUTDOWN_MV,   CSR_DATA_W'(shut));
      write_reg(CSR_SETTLE_TICKS,  CSR_DATA_W'(settle));
      write_reg(CSR_SENSE_ENABLE,  CSR_DATA_W'(sense));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (taken_total != queued_total || status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int n, input int ticks, input int s_idle, input int r_idle);
      tick_pct      = ticks;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int k = 0; k < n; k++) begin
         // hold the sender until the pipeline is empty once per phase
         if (k == n / 2) wait_drained();
         push_reading(next_reading());
      end
      wait_drained();
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      if (!reset && (!drive_valid || req_taken)) begin
         if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_q     <= pending_readings.pop_front();
            drive_valid <= 1'b1;
         end else begin
            drive_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready_q <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : observe
      status_type  due;
      reading_type seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            seen = '{req_if.command, req_if.ref_sample, req_if.batt_sample, req_if.on_mains};
            status_due.push_back(predict_status(seen));
            taken_total++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (status_due.size() == 0) begin
               $error("response transaction with no request outstanding");
               errors++;
            end else begin
               due = status_due.pop_front();
               check_field("accepted",         due.accepted,         rsp_if.accepted);
               check_field("filtered_level",   due.filtered_level,   rsp_if.filtered_level);
               check_field("battery_mv",       due.battery_mv,       rsp_if.battery_mv);
               check_field("low_warning",      due.low_warning,      rsp_if.low_warning);
               check_field("battery_absent",   due.battery_absent,   rsp_if.battery_absent);
               check_field("shutdown_request", due.shutdown_request, rsp_if.shutdown_request);
               check_field("recalibrate",      due.recalibrate,      rsp_if.recalibrate);
               check_field("no_sensing",       due.no_sensing,       rsp_if.no_sensing);
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_if.valid && req_if.ready) ||
             (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // window edges, arming the settle count, recalibrate after a reject run
      push_reading('{CMD_TICK, 12'd0,    12'd0,    1'b0});
      push_reading('{CMD_CONV, 12'd899,  12'd4095, 1'b0});
      push_reading('{CMD_CONV, 12'd1611, 12'd4095, 1'b1});
      push_reading('{CMD_CONV, 12'd0,    12'd0,    1'b0});
      push_reading('{CMD_CONV, 12'd4095, 12'd4095, 1'b1});
      push_reading('{CMD_CONV, 12'd900,  12'd4095, 1'b0});
      push_reading('{CMD_CONV, 12'd1610, 12'd4095, 1'b1});
      push_reading('{CMD_TICK, 12'd4095, 12'd4095, 1'b1});
      push_reading('{CMD_CONV, 12'd1234, 12'd0,    1'b0});
      for (int k = 0; k < 12; k++)
         push_reading('{CMD_CONV, (k % 2) ? 12'd899 : 12'd1611, 12'($urandom), 1'($urandom)});
      push_reading('{CMD_TICK, 12'hAAA,  12'h555,  1'b0});
      push_reading('{CMD_CONV, 12'd1000, 12'hAAA,  1'b1});
      push_reading('{CMD_CONV, 12'd1500, 12'h555,  1'b0});
      push_reading('{CMD_TICK, 12'h555,  12'hAAA,  1'b1});
      wait_drained();

      set_config(0, 4095, 11200, 11280, 500, 0, 65535, 1);
      run_phase(225, 30, 28, 63);
      set_config(900, 1610, 15000, 18000, 3000, 0, 120, 1);
      run_phase(450, 35, 28, 63);
      set_config(1610, 900, 26900, 0, 26900, 0, 0, 1);
      run_phase(150, 20, 63, 28);
      set_config(100, 4000, 0, 26900, 0, 0, 0, 0);
      run_phase(150, 20, 63, 28);
      set_config(RST_REF_LOW, RST_REF_HIGH, RST_LOW_WARN_MV, RST_WARN_CLEAR_MV,
                 RST_ABSENT_MV, RST_SHUTDOWN_MV, RST_SETTLE_TICKS, RST_SENSE_ENABLE);
      run_phase(450, 25, 63, 28);
      set_config(2000, 2000, 20000, 20000, 26900, 26900, 1000, 1);
      run_phase(300, 25, 0, 0);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && status_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/bvm_pkg.sv
rtl/bvm_req_if.sv
rtl/bvm_rsp_if.sv
rtl/battery_voltage_monitor_core.sv
tb/sv/tb.sv
